// ----- rtl/global_motion_vector_defines.svh -----
// Assertion macros shared by the global motion vector RTL.
// Depends on nothing; included by the top level only.
`ifndef GLOBAL_MOTION_VECTOR_DEFINES_SVH
`define GLOBAL_MOTION_VECTOR_DEFINES_SVH

// Same-cycle implication, checked at the rising clock edge outside reset.
`define GMV_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("global motion vector: same-cycle check failed");

// Next-cycle implication, checked at the rising clock edge outside reset.
`define GMV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("global motion vector: next-cycle check failed");

`endif

// ----- rtl/gmv_pkg.sv -----
// Shared types, widths and codes for the global motion vector block.
// No dependencies; imported by every module of the block.
package gmv_pkg;

   // Defaults of the top-level parameters
   localparam int unsigned POSITION_MAX_DEF = 16383;
   localparam int unsigned BLOCK_MAX_DEF    = 128;

   // Fixed-point layout of the model parameters
   localparam int unsigned PREC_BITS   = 16;
   localparam int unsigned TRANS_SHIFT = PREC_BITS - 3;   // translation down to 1/8 pel
   localparam int unsigned SHIFT_HP    = PREC_BITS - 3;   // affine rounding, eighth pel
   localparam int unsigned SHIFT_QP    = PREC_BITS - 2;   // affine rounding, coarser modes
   localparam int unsigned BLK_SHIFT   = 2;               // 4x4 units to pixels

   // Field widths
   localparam int unsigned POS_W      = 14;
   localparam int unsigned SIZE_W     = 8;
   localparam int unsigned TRANS_W    = 24;
   localparam int unsigned MAT_W      = 18;
   localparam int unsigned COEF_W     = MAT_W + 1;
   localparam int unsigned COORD_W    = POS_W + BLK_SHIFT + 2;
   localparam int unsigned PROD_W     = COEF_W + COORD_W;
   localparam int unsigned SUM_W      = PROD_W + 2;
   localparam int unsigned RND_W      = SUM_W + 1;
   localparam int unsigned MAG_W      = RND_W - SHIFT_HP + 1;
   localparam int unsigned LOW_W      = MAG_W + 1;
   localparam int unsigned TSH_W      = TRANS_W - TRANS_SHIFT;
   localparam int unsigned VEC_W      = 24;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   // Delay from accepted item to its result strobe, in clock cycles
   localparam int unsigned LATENCY = 7;

   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << PREC_BITS);

   // Precision modes; any code above integer pel behaves as integer pel
   localparam logic [1:0] PREC_EIGHTH  = 2'd0;
   localparam logic [1:0] PREC_QUARTER = 2'd1;
   localparam logic [1:0] PREC_INTEGER = 2'd2;

   typedef enum logic [1:0] {
      MODEL_IDENTITY,
      MODEL_TRANSLATION,
      MODEL_ROTZOOM,
      MODEL_AFFINE
   } gmv_model_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODEL_TYPE,
      CSR_TRANSLATION_X,
      CSR_TRANSLATION_Y,
      CSR_MATRIX_XX,
      CSR_MATRIX_XY,
      CSR_MATRIX_YX,
      CSR_MATRIX_YY,
      CSR_PRECISION_MODE
   } gmv_csr_type;

   // Configuration as the datapath sees it; diagonal terms hold (m - 1.0)
   typedef struct packed {
      gmv_model_type             model;
      logic signed [TRANS_W-1:0] trans_x;
      logic signed [TRANS_W-1:0] trans_y;
      logic signed [COEF_W-1:0]  coef_xx;
      logic signed [COEF_W-1:0]  coef_xy;
      logic signed [COEF_W-1:0]  coef_yx;
      logic signed [COEF_W-1:0]  coef_yy;
      logic [1:0]                precision;
   } gmv_cfg_type;

   // Block centre in pixels, leaving the coordinate stage
   typedef struct packed {
      logic                      valid;
      logic                      invalid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } gmv_coord_type;

   // Affine sums at 16 fractional bits, leaving the affine stages
   typedef struct packed {
      logic                    valid;
      logic                    invalid;
      logic signed [SUM_W-1:0] cx;
      logic signed [SUM_W-1:0] cy;
   } gmv_sum_type;

endpackage

// ----- rtl/global_motion_vector.sv -----
// Global motion vector top level: configuration registers and the pipeline.
// Depends on gmv_pkg, gmv_coord, gmv_affine, gmv_round and the defines header.
//
// One item per clock: an item is taken whenever start is high and busy is low,
// and its result appears on the rsp_ ports with rsp_valid after the register
// stages below, one strobe per item, in order. The depth is set by the datapath:
// centre calculation, the registered affine multiplies, the sum, the sign and
// magnitude split, rounding, precision lowering and saturation each take one
// register stage. Results cannot be held off, so nothing ever stalls. busy is
// high during reset and for the first cycle after it, and low from then on.
// Configuration registers are written through csr_write/csr_index/csr_wdata
// and must only change while no item is in flight.
`include "global_motion_vector_defines.svh"

module global_motion_vector #(
   parameter int unsigned POSITION_MAX = gmv_pkg::POSITION_MAX_DEF,
   parameter int unsigned BLOCK_MAX    = gmv_pkg::BLOCK_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gmv_pkg::POS_W-1:0]         req_block_row,
   input  logic [gmv_pkg::POS_W-1:0]         req_block_col,
   input  logic [gmv_pkg::SIZE_W-1:0]        req_width_pixels,
   input  logic [gmv_pkg::SIZE_W-1:0]        req_height_pixels,
   output logic                              rsp_valid,
   output logic signed [gmv_pkg::VEC_W-1:0]  rsp_vector_row,
   output logic signed [gmv_pkg::VEC_W-1:0]  rsp_vector_col,
   output logic                              rsp_invalid,
   input  logic                              csr_write,
   input  logic [gmv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gmv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import gmv_pkg::*;

   gmv_cfg_type   cfg_ff;
   gmv_cfg_type   cfg_in;
   logic          busy_ff;
   logic          in_accept;
   gmv_coord_type coord;
   gmv_sum_type   sums;
   logic [VEC_W-1:0] vec_row;
   logic [VEC_W-1:0] vec_col;

   // register writes; diagonal terms are stored with 1.0 taken off
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (gmv_csr_type'(csr_index))
            CSR_MODEL_TYPE:     cfg_in.model     = gmv_model_type'(csr_wdata[1:0]);
            CSR_TRANSLATION_X:  cfg_in.trans_x   = $signed(csr_wdata[TRANS_W-1:0]);
            CSR_TRANSLATION_Y:  cfg_in.trans_y   = $signed(csr_wdata[TRANS_W-1:0]);
            CSR_MATRIX_XX:      cfg_in.coef_xx   = COEF_W'($signed(csr_wdata[MAT_W-1:0]))
                                                 - COEF_ONE;
            CSR_MATRIX_XY:      cfg_in.coef_xy   = COEF_W'($signed(csr_wdata[MAT_W-1:0]));
            CSR_MATRIX_YX:      cfg_in.coef_yx   = COEF_W'($signed(csr_wdata[MAT_W-1:0]));
            CSR_MATRIX_YY:      cfg_in.coef_yy   = COEF_W'($signed(csr_wdata[MAT_W-1:0]))
                                                 - COEF_ONE;
            CSR_PRECISION_MODE: cfg_in.precision = csr_wdata[1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.model     <= MODEL_IDENTITY;
         cfg_ff.trans_x   <= '0;
         cfg_ff.trans_y   <= '0;
         cfg_ff.coef_xx   <= '0;
         cfg_ff.coef_xy   <= '0;
         cfg_ff.coef_yx   <= '0;
         cfg_ff.coef_yy   <= '0;
         cfg_ff.precision <= PREC_EIGHTH;
         busy_ff          <= 1'b1;
      end else begin
         cfg_ff  <= cfg_in;
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign in_accept = start & ~busy_ff;

   gmv_coord #(
      .POSITION_MAX (POSITION_MAX),
      .BLOCK_MAX    (BLOCK_MAX)
   ) u_coord (
      .clock         (clock),
      .reset         (reset),
      .accept        (in_accept),
      .block_row     (req_block_row),
      .block_col     (req_block_col),
      .width_pixels  (req_width_pixels),
      .height_pixels (req_height_pixels),
      .coord_out     (coord)
   );

   gmv_affine u_affine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .coord_in (coord),
      .sum_out  (sums)
   );

   gmv_round u_round (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .sum_in         (sums),
      .rsp_valid      (rsp_valid),
      .rsp_invalid    (rsp_invalid),
      .rsp_vector_row (vec_row),
      .rsp_vector_col (vec_col)
   );

   assign rsp_vector_row = $signed(vec_row);
   assign rsp_vector_col = $signed(vec_col);

   // checks
   `GMV_ASSERT_IMPLY(a_latency, clock, reset, 1'b1, rsp_valid == $past(in_accept, LATENCY))
   `GMV_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && rsp_invalid,
                     (rsp_vector_row == '0) && (rsp_vector_col == '0))
   `GMV_ASSERT_IMPLY(a_trans_range, clock, reset,
                     rsp_valid && (cfg_ff.model == MODEL_TRANSLATION),
                     (rsp_vector_row >= -24'sd1024) && (rsp_vector_row <= 24'sd1024) &&
                     (rsp_vector_col >= -24'sd1024) && (rsp_vector_col <= 24'sd1024))
   `GMV_ASSERT_NEXT(a_busy_release, clock, reset, !$past(reset), !busy)

endmodule

// ----- rtl/gmv_coord.sv -----
// Coordinate stage: clamps position and size, forms the block centre.
// Depends on gmv_pkg.
module gmv_coord #(
   parameter int unsigned POSITION_MAX = gmv_pkg::POSITION_MAX_DEF,
   parameter int unsigned BLOCK_MAX    = gmv_pkg::BLOCK_MAX_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [gmv_pkg::POS_W-1:0]    block_row,
   input  logic [gmv_pkg::POS_W-1:0]    block_col,
   input  logic [gmv_pkg::SIZE_W-1:0]   width_pixels,
   input  logic [gmv_pkg::SIZE_W-1:0]   height_pixels,
   output gmv_pkg::gmv_coord_type       coord_out
);
   import gmv_pkg::*;

   localparam logic [16:0] POS_LIM  = 17'(POSITION_MAX);
   localparam logic [8:0]  SIZE_LIM = 9'(BLOCK_MAX);

   logic [POS_W-1:0]         row_sat;
   logic [POS_W-1:0]         col_sat;
   logic [SIZE_W-1:0]        w_sat;
   logic [SIZE_W-1:0]        h_sat;
   logic                     valid_ff;
   logic                     invalid_ff;
   logic                     invalid_in;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic signed [COORD_W-1:0] x_in;
   logic signed [COORD_W-1:0] y_in;

   // saturate position and size
   assign row_sat = (17'(block_row) > POS_LIM) ? POS_LIM[POS_W-1:0] : block_row;
   assign col_sat = (17'(block_col) > POS_LIM) ? POS_LIM[POS_W-1:0] : block_col;
   assign w_sat   = (9'(width_pixels) > SIZE_LIM) ? SIZE_LIM[SIZE_W-1:0] : width_pixels;
   assign h_sat   = (9'(height_pixels) > SIZE_LIM) ? SIZE_LIM[SIZE_W-1:0] : height_pixels;

   // centre pixel: pos*4 + size/2 - 1
   assign x_in = $signed({2'b00, col_sat, 2'b00})
               + $signed({{(COORD_W-SIZE_W+1){1'b0}}, w_sat[SIZE_W-1:1]})
               - COORD_W'(1);
   assign y_in = $signed({2'b00, row_sat, 2'b00})
               + $signed({{(COORD_W-SIZE_W+1){1'b0}}, h_sat[SIZE_W-1:1]})
               - COORD_W'(1);
   assign invalid_in = (width_pixels == '0) || (height_pixels == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      invalid_ff <= invalid_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
   end

   assign coord_out.valid   = valid_ff;
   assign coord_out.invalid = invalid_ff;
   assign coord_out.x       = x_ff;
   assign coord_out.y       = y_ff;

endmodule

// ----- rtl/gmv_affine.sv -----
// Affine evaluation: four registered products, then the registered sums.
// Depends on gmv_pkg.
module gmv_affine (
   input  logic                   clock,
   input  logic                   reset,
   input  gmv_pkg::gmv_cfg_type   cfg,
   input  gmv_pkg::gmv_coord_type coord_in,
   output gmv_pkg::gmv_sum_type   sum_out
);
   import gmv_pkg::*;

   logic                     valid2_ff;
   logic                     invalid2_ff;
   logic signed [PROD_W-1:0] p_xx_ff, p_xy_ff, p_yx_ff, p_yy_ff;
   logic signed [PROD_W-1:0] p_xx_in, p_xy_in, p_yx_in, p_yy_in;
   logic                     valid3_ff;
   logic                     invalid3_ff;
   logic signed [SUM_W-1:0]  cx_ff, cy_ff;
   logic signed [SUM_W-1:0]  cx_in, cy_in;

   // products of the model matrix with the block centre
   assign p_xx_in = cfg.coef_xx * coord_in.x;
   assign p_xy_in = cfg.coef_xy * coord_in.y;
   assign p_yx_in = cfg.coef_yx * coord_in.x;
   assign p_yy_in = cfg.coef_yy * coord_in.y;

   // add the translation terms
   assign cx_in = SUM_W'(p_xx_ff) + SUM_W'(p_xy_ff) + SUM_W'(cfg.trans_x);
   assign cy_in = SUM_W'(p_yx_ff) + SUM_W'(p_yy_ff) + SUM_W'(cfg.trans_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid2_ff <= coord_in.valid;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      invalid2_ff <= coord_in.invalid;
      p_xx_ff     <= p_xx_in;
      p_xy_ff     <= p_xy_in;
      p_yx_ff     <= p_yx_in;
      p_yy_ff     <= p_yy_in;
      invalid3_ff <= invalid2_ff;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
   end

   assign sum_out.valid   = valid3_ff;
   assign sum_out.invalid = invalid3_ff;
   assign sum_out.cx      = cx_ff;
   assign sum_out.cy      = cy_ff;

endmodule

// ----- rtl/gmv_round.sv -----
// Output stages: sign/magnitude split, rounding, precision lowering, saturation.
// Depends on gmv_pkg. Lane 0 is the row component, lane 1 the column.
module gmv_round (
   input  logic                       clock,
   input  logic                       reset,
   input  gmv_pkg::gmv_cfg_type       cfg,
   input  gmv_pkg::gmv_sum_type       sum_in,
   output logic                       rsp_valid,
   output logic                       rsp_invalid,
   output logic [gmv_pkg::VEC_W-1:0]  rsp_vector_row,
   output logic [gmv_pkg::VEC_W-1:0]  rsp_vector_col
);
   import gmv_pkg::*;

   localparam logic [LOW_W-1:0] POS_LIMIT = LOW_W'((1 << (VEC_W - 1)) - 1);
   localparam logic [LOW_W-1:0] NEG_LIMIT = LOW_W'(1 << (VEC_W - 1));

   logic                     is_affine;
   logic                     is_trans;
   logic                     hp;
   logic                     to_integer;
   logic signed [SUM_W-1:0]  src [2];
   logic signed [TSH_W-1:0]  tsh [2];
   logic signed [SUM_W-1:0]  pick [2];
   logic                     neg4_in [2];
   logic [SUM_W-1:0]         mag4_in [2];
   logic                     valid4_ff, invalid4_ff, affine4_ff;
   logic                     neg4_ff [2];
   logic [SUM_W-1:0]         mag4_ff [2];
   logic [RND_W-1:0]         rnd [2];
   logic [MAG_W-1:0]         m5_in [2];
   logic                     valid5_ff, invalid5_ff;
   logic                     neg5_ff [2];
   logic [MAG_W-1:0]         m5_ff [2];
   logic [LOW_W-1:0]         up3 [2];
   logic [LOW_W-1:0]         m6_in [2];
   logic                     valid6_ff, invalid6_ff;
   logic                     neg6_ff [2];
   logic [LOW_W-1:0]         m6_ff [2];
   logic [VEC_W-1:0]         vec_in [2];
   logic                     rsp_valid_ff, rsp_invalid_ff;
   logic [VEC_W-1:0]         vec_ff [2];

   assign is_affine  = (cfg.model == MODEL_ROTZOOM) || (cfg.model == MODEL_AFFINE);
   assign is_trans   = (cfg.model == MODEL_TRANSLATION);
   assign hp         = (cfg.precision == PREC_EIGHTH);
   assign to_integer = (cfg.precision >= PREC_INTEGER);

   // row takes the y sum and translation_x, column the x sum and translation_y
   assign src[0] = sum_in.cy;
   assign src[1] = sum_in.cx;
   assign tsh[0] = TSH_W'(cfg.trans_x >>> TRANS_SHIFT);
   assign tsh[1] = TSH_W'(cfg.trans_y >>> TRANS_SHIFT);

   // stage 4: pick the source value and split sign and magnitude
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (sum_in.invalid) begin
            pick[i] = '0;
         end else if (is_affine) begin
            pick[i] = src[i];
         end else if (is_trans) begin
            pick[i] = SUM_W'(tsh[i]);
         end else begin
            pick[i] = '0;
         end
         neg4_in[i] = pick[i][SUM_W-1];
         mag4_in[i] = neg4_in[i] ? -pick[i] : pick[i];
      end
   end

   // stage 5: for affine models, round half away from zero, doubled in the coarser modes; others pass
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rnd[i] = RND_W'(mag4_ff[i])
                + (hp ? RND_W'(1 << (SHIFT_HP - 1)) : RND_W'(1 << (SHIFT_QP - 1)));
         if (!affine4_ff) begin
            m5_in[i] = MAG_W'(mag4_ff[i]);
         end else if (hp) begin
            m5_in[i] = MAG_W'(rnd[i][RND_W-1:SHIFT_HP]);
         end else begin
            m5_in[i] = MAG_W'({rnd[i][RND_W-1:SHIFT_QP], 1'b0});
         end
      end
   end

   // stage 6: lower the precision on the magnitude
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         up3[i] = LOW_W'(m5_ff[i]) + LOW_W'(3);
         if (hp) begin
            m6_in[i] = LOW_W'(m5_ff[i]);
         end else if (to_integer) begin
            m6_in[i] = {up3[i][LOW_W-1:3], 3'b000};
         end else begin
            m6_in[i] = {1'b0, m5_ff[i][MAG_W-1:1], 1'b0};
         end
      end
   end

   // output stage: saturate to 24 bits and restore the sign
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         if (neg6_ff[i]) begin
            vec_in[i] = (m6_ff[i] >= NEG_LIMIT) ? NEG_LIMIT[VEC_W-1:0]
                                                : -m6_ff[i][VEC_W-1:0];
         end else begin
            vec_in[i] = (m6_ff[i] > POS_LIMIT) ? POS_LIMIT[VEC_W-1:0]
                                               : m6_ff[i][VEC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff    <= 1'b0;
         valid5_ff    <= 1'b0;
         valid6_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid4_ff    <= sum_in.valid;
         valid5_ff    <= valid4_ff;
         valid6_ff    <= valid5_ff;
         rsp_valid_ff <= valid6_ff;
      end
   end

   always_ff @(posedge clock) begin
      invalid4_ff    <= sum_in.invalid;
      affine4_ff     <= is_affine;
      invalid5_ff    <= invalid4_ff;
      invalid6_ff    <= invalid5_ff;
      rsp_invalid_ff <= invalid6_ff;
      for (int i = 0; i < 2; i++) begin
         neg4_ff[i] <= neg4_in[i];
         mag4_ff[i] <= mag4_in[i];
         neg5_ff[i] <= neg4_ff[i];
         m5_ff[i]   <= m5_in[i];
         neg6_ff[i] <= neg5_ff[i];
         m6_ff[i]   <= m6_in[i];
         vec_ff[i]  <= vec_in[i];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_invalid    = rsp_invalid_ff;
   assign rsp_vector_row = vec_ff[0];
   assign rsp_vector_col = vec_ff[1];

endmodule
